### hdl/mrpt_pkg.sv
// Package for the 64-bit Miller-Rabin primality tester.
// Holds the small-prime table and widths; no dependencies.
`default_nettype none
package mrpt_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned NumPrimes = 12;
  localparam int unsigned PrimeIdxW = 4;
  typedef logic [WordW-1:0] word_t;
  typedef logic [PrimeIdxW-1:0] pidx_t;

  function automatic logic [5:0] small_prime(input pidx_t idx);
    logic [5:0] p;
    case (idx)
      4'd0: p = 6'd2;
      4'd1: p = 6'd3;
      4'd2: p = 6'd5;
      4'd3: p = 6'd7;
      4'd4: p = 6'd11;
      4'd5: p = 6'd13;
      4'd6: p = 6'd17;
      4'd7: p = 6'd19;
      4'd8: p = 6'd23;
      4'd9: p = 6'd29;
      4'd10: p = 6'd31;
      4'd11: p = 6'd37;
      default: p = 6'd2;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

### hdl/mrpt_if.sv
// Valid/ready channel interfaces for the primality tester.
// Depends on mrpt_pkg.
`default_nettype none
interface mrpt_in_if (input wire logic clk);
  logic valid;
  logic ready;
  mrpt_pkg::word_t candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface mrpt_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

### hdl/miller_rabin_prime_test_64.sv
// Top level of the 64-bit deterministic Miller-Rabin primality tester.
// Depends on mrpt_pkg and mrpt_if.
//
// One candidate at a time. Modular multiply steps (doubling, conditional
// add) run through one shared 65-bit add/compare unit; trial division uses
// its own small remainder compare. A trial division shifts in all 64
// candidate bits for each small prime, then checks the remainder. A modular
// multiply doubles once per multiplier bit and adds once per set bit. A
// prime near 2^64 needs about 96 multiplies per base over 12 bases. The
// result sits in an output register; the next candidate is taken once it
// transfers.
`default_nettype none
module miller_rabin_prime_test_64 (
  input wire logic clk,
  input wire logic rst_n,
  mrpt_in_if.sink in_ch,
  mrpt_out_if.source out_ch
);
  import mrpt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TDIV  = 4'd1;
  localparam logic [3:0] S_TCHK  = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_BASE  = 4'd4;
  localparam logic [3:0] S_PSTEP = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_PCHK  = 4'd7;
  localparam logic [3:0] S_SQCHK = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // multiply purpose codes
  localparam logic [1:0] M_ACC = 2'd0;
  localparam logic [1:0] M_BSQ = 2'd1;
  localparam logic [1:0] M_XSQ = 2'd2;

  logic [3:0] st_r, st_nxt;
  word_t n_r, n_nxt, d_r, d_nxt, ex_r, ex_nxt;
  word_t acc_r, acc_nxt, b_r, b_nxt;
  word_t ma_r, ma_nxt, mb_r, mb_nxt, mp_r, mp_nxt;
  logic [5:0] rem_r, rem_nxt;
  logic [5:0] bit_r, bit_nxt;
  logic [6:0] s_r, s_nxt, r_r, r_nxt;
  logic       addx_r, addx_nxt;
  logic [1:0] mk_r, mk_nxt;
  pidx_t      pi_r, pi_nxt;
  logic       res_r, res_nxt;

  // shared add/compare unit: (u + v) mod n for u, v < n
  word_t u_s, v_s, modsum;
  logic [WordW:0] sum_w;
  logic [6:0] rem2;
  logic [5:0] pr;
  word_t top;

  assign top = n_r - 64'd1;
  assign sum_w = {1'b0, u_s} + {1'b0, v_s};
  assign modsum = (sum_w >= {1'b0, n_r}) ? word_t'(sum_w - {1'b0, n_r}) : sum_w[WordW-1:0];
  assign pr = small_prime(pi_r);
  assign rem2 = {rem_r, n_r[bit_r]};

  always_comb begin
    u_s = mp_r;
    v_s = addx_r ? ma_r : mp_r;
  end

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_DONE);
  assign out_ch.is_prime = res_r;

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; d_nxt = d_r; ex_nxt = ex_r;
    acc_nxt = acc_r; b_nxt = b_r; ma_nxt = ma_r; mb_nxt = mb_r; mp_nxt = mp_r;
    rem_nxt = rem_r; bit_nxt = bit_r; s_nxt = s_r; r_nxt = r_r;
    addx_nxt = addx_r; mk_nxt = mk_r; pi_nxt = pi_r; res_nxt = res_r;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          n_nxt = in_ch.candidate;
          pi_nxt = '0; rem_nxt = '0; bit_nxt = 6'd63;
          if (in_ch.candidate < 64'd2) begin
            res_nxt = 1'b0; st_nxt = S_DONE;
          end else begin
            st_nxt = S_TDIV;
          end
        end
      end
      S_TDIV: begin
        // restoring remainder, one bit per cycle
        if (rem2 >= {1'b0, pr}) rem_nxt = 6'(rem2 - {1'b0, pr});
        else rem_nxt = rem2[5:0];
        bit_nxt = bit_r - 6'd1;
        if (bit_r == 6'd0) st_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (n_r == {58'd0, pr}) begin
          res_nxt = 1'b1; st_nxt = S_DONE;
        end else if (rem_r == 6'd0) begin
          res_nxt = 1'b0; st_nxt = S_DONE;
        end else if (pi_r == pidx_t'(NumPrimes - 1)) begin
          d_nxt = n_r - 64'd1; s_nxt = '0; st_nxt = S_SPLIT;
        end else begin
          pi_nxt = pi_r + 4'd1; rem_nxt = '0; bit_nxt = 6'd63; st_nxt = S_TDIV;
        end
      end
      S_SPLIT: begin
        if (d_r[0]) begin
          pi_nxt = '0; st_nxt = S_BASE;
        end else begin
          d_nxt = d_r >> 1; s_nxt = s_r + 7'd1;
        end
      end
      S_BASE: begin
        acc_nxt = 64'd1; b_nxt = {58'd0, pr}; ex_nxt = d_r; st_nxt = S_PSTEP;
      end
      S_PSTEP: begin
        if (ex_r == '0) begin
          st_nxt = S_PCHK;
        end else if (ex_r[0]) begin
          ma_nxt = acc_r; mb_nxt = b_r; mk_nxt = M_ACC;
          mp_nxt = '0; bit_nxt = 6'd63; addx_nxt = 1'b0; st_nxt = S_MUL;
        end else begin
          ma_nxt = b_r; mb_nxt = b_r; mk_nxt = M_BSQ;
          mp_nxt = '0; bit_nxt = 6'd63; addx_nxt = 1'b0; st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // per bit: double, then add if the multiplier bit is set
        if (!addx_r) begin
          mp_nxt = modsum;
          if (mb_r[bit_r]) addx_nxt = 1'b1;
          else if (bit_r == 6'd0) st_nxt = S_IDLE; // replaced below
          else bit_nxt = bit_r - 6'd1;
        end else begin
          mp_nxt = modsum; addx_nxt = 1'b0;
          if (bit_r != 6'd0) bit_nxt = bit_r - 6'd1;
        end
        if ((addx_r || !mb_r[bit_r]) && bit_r == 6'd0) begin
          st_nxt = S_PSTEP;
          case (mk_r)
            M_ACC: begin
              acc_nxt = modsum;
              ma_nxt = b_r; mb_nxt = b_r; mk_nxt = M_BSQ;
              mp_nxt = '0; bit_nxt = 6'd63; addx_nxt = 1'b0; st_nxt = S_MUL;
            end
            M_BSQ: begin
              b_nxt = modsum; ex_nxt = ex_r >> 1;
            end
            M_XSQ: begin
              acc_nxt = modsum; st_nxt = S_SQCHK;
            end
            default: st_nxt = S_PSTEP;
          endcase
        end
      end
      S_PCHK: begin
        r_nxt = 7'd1;
        if (acc_r == 64'd1 || acc_r == top) st_nxt = S_SQCHK;
        else if (s_r <= 7'd1) begin
          res_nxt = 1'b0; st_nxt = S_DONE;
        end else begin
          ma_nxt = acc_r; mb_nxt = acc_r; mk_nxt = M_XSQ;
          mp_nxt = '0; bit_nxt = 6'd63; addx_nxt = 1'b0; st_nxt = S_MUL;
        end
        if (acc_r == 64'd1 || acc_r == top) begin
          r_nxt = s_r; // mark passed
          acc_nxt = top;
        end
      end
      S_SQCHK: begin
        if (acc_r == top) begin
          if (pi_r == pidx_t'(NumPrimes - 1)) begin
            res_nxt = 1'b1; st_nxt = S_DONE;
          end else begin
            pi_nxt = pi_r + 4'd1; st_nxt = S_BASE;
          end
        end else if (r_r + 7'd1 >= s_r) begin
          res_nxt = 1'b0; st_nxt = S_DONE;
        end else begin
          r_nxt = r_r + 7'd1;
          ma_nxt = acc_r; mb_nxt = acc_r; mk_nxt = M_XSQ;
          mp_nxt = '0; bit_nxt = 6'd63; addx_nxt = 1'b0; st_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (out_ch.ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    n_r <= n_nxt; d_r <= d_nxt; ex_r <= ex_nxt; acc_r <= acc_nxt; b_r <= b_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; mp_r <= mp_nxt; rem_r <= rem_nxt;
    bit_r <= bit_nxt; s_r <= s_nxt; r_r <= r_nxt; addx_r <= addx_nxt;
    mk_r <= mk_nxt; pi_r <= pi_nxt; res_r <= res_nxt;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.is_prime))
    else $error("result dropped");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("double accept");
endmodule
`default_nettype wire
